// ===== rtl/core/tvsm_pkg.sv =====
// Shared types and constants for the triangle vote star matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tvsm_pkg;
	localparam int MaxStars = 32;
	localparam int MaxTris = 4096;
	localparam int StarW = $clog2(MaxStars);
	localparam int TriAw = $clog2(MaxTris);
	localparam int CntW = TriAw + 1;
	localparam int CellAw = 2 * StarW;

	localparam logic [1:0] CMD_LOAD_REF = 2'd0;
	localparam logic [1:0] CMD_LOAD_FRM = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_RSC = 2'd1;
	localparam logic [1:0] REG_FSC = 2'd2;

	typedef struct packed {
		logic [StarW-1:0] s1;
		logic [StarW-1:0] s2;
		logic [StarW-1:0] s3;
		logic [15:0] rm;
		logic [15:0] rs;
	} tri_t;

	// vote request to the vote store
	typedef struct packed {
		logic vld;
		logic [CellAw-1:0] addr;
	} vote_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/tvsm_tri_ram.sv =====
// Triangle store with one write port and one registered read port.
// Depends on tvsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tvsm_tri_ram (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [tvsm_pkg::TriAw-1:0] waddr,
	input  wire tvsm_pkg::tri_t wdata,
	input  wire logic [tvsm_pkg::TriAw-1:0] raddr,
	output tvsm_pkg::tri_t rdata
);
	tvsm_pkg::tri_t mem [tvsm_pkg::MaxTris];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/tvsm_vote_ram.sv =====
// Vote matrix store: saturating read-modify-write with forwarding; the rmw read port
// also serves the row scan. Depends on tvsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tvsm_vote_ram (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tvsm_pkg::vote_req_t req,
	input  wire logic clr_we,
	input  wire logic [tvsm_pkg::CellAw-1:0] clr_addr,
	input  wire logic [tvsm_pkg::CellAw-1:0] raddr,
	output logic [15:0] rdata
);
	logic [15:0] mem [tvsm_pkg::MaxStars*tvsm_pkg::MaxStars];
	logic [15:0] rmw_s1;
	logic [tvsm_pkg::CellAw-1:0] addr_s1;
	logic vld_s1;
	logic [15:0] cur, nxt;
	logic [tvsm_pkg::CellAw-1:0] ra;
	// the rmw read port doubles as the scan port when no vote is in flight
	assign ra = req.vld ? req.addr : raddr;
	always_ff @(posedge clk) begin
		rmw_s1 <= mem[ra];
		if (clr_we) mem[clr_addr] <= '0;
		else if (vld_s1) mem[addr_s1] <= nxt;
	end
	assign rdata = cur;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= req.vld;
	end
	always_ff @(posedge clk) addr_s1 <= req.addr;
	// forward the write when the cell read at the same edge is the one being written
	logic fwd_q;
	logic [15:0] last_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_q <= 1'b0;
		else fwd_q <= vld_s1 && (ra == addr_s1);
	end
	always_ff @(posedge clk) last_q <= nxt;
	assign cur = fwd_q ? last_q : rmw_s1;
	assign nxt = (cur == 16'hFFFF) ? cur : cur + 16'd1;
endmodule
`default_nettype wire

// ===== rtl/core/triangle_vote_star_matcher_unit.sv =====
// Triangle vote star matcher: input channel, APB registers, triangle and vote stores.
// Depends on tvsm_pkg, tvsm_tri_ram, tvsm_vote_ram.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Input words (valid/stall) carry a command and one triangle. Loads are taken one
//  per cycle while idle and give no result; a load into a full store is dropped and
//  flagged. A compute word clears the vote matrix (1024 cells, one cell a cycle),
//  then walks every reference/frame pair: one store read, then three vote steps,
//  each voting one cell if the triangles match and its stars are in range. Each
//  reference row is then scanned with vote store reads, one cell a cycle, and
//  then loads its result word.
//  One result word per reference row follows on the output channel (valid/stall);
//  last marks the final row. While the output is stalled the next row is scanned,
//  then its word waits until the held word is taken.
//  No input is accepted during a compute. Reset clears counts, overflow flag and
//  restores the register defaults; stores are not swept by reset.
//  Registers: 0 match_tolerance, 1 ref_star_count, 2 frame_star_count (byte addr 4*i).
module triangle_vote_star_matcher_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [1:0] command,
	input  wire logic [4:0] star_first,
	input  wire logic [4:0] star_second,
	input  wire logic [4:0] star_third,
	input  wire logic [15:0] ratio_middle,
	input  wire logic [15:0] ratio_shortest,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [4:0] ref_star,
	output logic [4:0] best_frame_star,
	output logic [15:0] corrected_vote,
	output logic overflow,
	output logic last
);
	localparam int SW = tvsm_pkg::StarW;
	localparam int AW = tvsm_pkg::TriAw;
	localparam int CW = tvsm_pkg::CntW;
	localparam int MS = tvsm_pkg::MaxStars;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR = 3'd1;
	localparam logic [2:0] ST_PAIR = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [15:0] tol_q;
	logic [5:0] rsc_q, fsc_q;
	logic [CW-1:0] rcnt_q, fcnt_q;
	logic ovf_q;
	logic [2:0] st_q;

	// registers
	logic [1:0] ridx;
	assign ridx = paddr[3:2];
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd328;
			rsc_q <= 6'd32;
			fsc_q <= 6'd32;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				tvsm_pkg::REG_TOL: tol_q <= pwdata[15:0];
				tvsm_pkg::REG_RSC: rsc_q <= pwdata[5:0];
				tvsm_pkg::REG_FSC: fsc_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (ridx)
			tvsm_pkg::REG_TOL: prdata = {16'd0, tol_q};
			tvsm_pkg::REG_RSC: prdata = {26'd0, rsc_q};
			tvsm_pkg::REG_FSC: prdata = {26'd0, fsc_q};
			default: prdata = '0;
		endcase
	end

	logic [6:0] rc, fc;
	assign rc = (rsc_q > 6'(MS)) ? 7'(MS) : {1'b0, rsc_q};
	assign fc = (fsc_q > 6'(MS)) ? 7'(MS) : {1'b0, fsc_q};

	logic acc;
	assign in_stall = (st_q != ST_IDLE);
	assign acc = in_valid && !in_stall;

	logic emit_go;
	assign emit_go = (st_q == ST_EMIT) && !(out_valid && out_stall);

	tvsm_pkg::tri_t win, rt, ft;
	assign win = '{s1: star_first, s2: star_second, s3: star_third,
		rm: ratio_middle, rs: ratio_shortest};
	logic rwe, fwe;
	assign rwe = acc && command == tvsm_pkg::CMD_LOAD_REF && !rcnt_q[AW];
	assign fwe = acc && command == tvsm_pkg::CMD_LOAD_FRM && !fcnt_q[AW];

	logic [AW-1:0] a_q, b_q;
	logic [1:0] k_q;
	tvsm_tri_ram u_ref (.clk(clk), .we(rwe), .waddr(rcnt_q[AW-1:0]), .wdata(win),
		.raddr(a_q), .rdata(rt));
	tvsm_tri_ram u_frm (.clk(clk), .we(fwe), .waddr(fcnt_q[AW-1:0]), .wdata(win),
		.raddr(b_q), .rdata(ft));

	// vote store
	tvsm_pkg::vote_req_t vreq;
	logic [tvsm_pkg::CellAw-1:0] clr_q, vraddr;
	logic [15:0] vrd;
	logic [SW:0] col_q;
	logic [SW-1:0] row_q;
	assign vraddr = {row_q, col_q[SW-1:0]};
	tvsm_vote_ram u_vote (.clk(clk), .arst_n(arst_n), .req(vreq),
		.clr_we(st_q == ST_CLR), .clr_addr(clr_q), .raddr(vraddr), .rdata(vrd));

	// pair walk: k 0 reads both triangle entries, 1..3 each vote one cell on a match
	logic match;
	logic [15:0] dm, ds;
	logic [16:0] dsum;
	assign dm = (rt.rm > ft.rm) ? rt.rm - ft.rm : ft.rm - rt.rm;
	assign ds = (rt.rs > ft.rs) ? rt.rs - ft.rs : ft.rs - rt.rs;
	assign dsum = {1'b0, dm} + {1'b0, ds};
	assign match = dsum < {1'b0, tol_q};
	logic [SW-1:0] rs_k, fs_k;
	always_comb begin
		case (k_q)
			2'd1: begin rs_k = rt.s1; fs_k = ft.s1; end
			2'd2: begin rs_k = rt.s2; fs_k = ft.s2; end
			default: begin rs_k = rt.s3; fs_k = ft.s3; end
		endcase
		vreq.vld = st_q == ST_PAIR && k_q != 2'd0 && match
			&& {2'b0, rs_k} < rc && {2'b0, fs_k} < fc;
		vreq.addr = {rs_k, fs_k};
	end

	// scan state
	logic [15:0] bv_q, ov_q;
	logic [SW-1:0] bc_q;
	logic rd_s1;
	logic [SW-1:0] rcol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rcnt_q <= '0;
			fcnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			clr_q <= '0;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			row_q <= '0;
			col_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			if (emit_go) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (acc) begin
					if (rwe) rcnt_q <= rcnt_q + 1'b1;
					if (fwe) fcnt_q <= fcnt_q + 1'b1;
					if ((command == tvsm_pkg::CMD_LOAD_REF && rcnt_q[AW]) ||
						(command == tvsm_pkg::CMD_LOAD_FRM && fcnt_q[AW])) ovf_q <= 1'b1;
					if (command == tvsm_pkg::CMD_COMPUTE) begin
						st_q <= ST_CLR;
						clr_q <= '0;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						a_q <= '0;
						b_q <= '0;
						k_q <= '0;
						if (rcnt_q == '0 || fcnt_q == '0) st_q <= ST_SCAN;
						else st_q <= ST_PAIR;
						row_q <= '0;
						col_q <= '0;
						rd_s1 <= 1'b0;
					end
				end
				ST_PAIR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd0) ;
					else if (k_q == 2'd3) begin
						if ({1'b0, b_q} + 1'b1 == fcnt_q) begin
							b_q <= '0;
							if ({1'b0, a_q} + 1'b1 == rcnt_q) begin
								st_q <= ST_SCAN;
								k_q <= '0;
							end else a_q <= a_q + 1'b1;
						end else b_q <= b_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (rc == '0) begin
						st_q <= ST_IDLE;
						fcnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						// issue reads col 0..fc-1, each result lands in the following cycle
						rd_s1 <= {1'b0, col_q} < {1'b0, fc[SW:0]} && col_q < (SW+1)'(MS);
						rcol_s1 <= col_q[SW-1:0];
						if (col_q == '0) begin
							bv_q <= '0;
							ov_q <= '0;
							bc_q <= '0;
						end
						if (rd_s1) begin
							if (rcol_s1 == '0) bv_q <= vrd;
							else if (vrd > bv_q) begin
								bv_q <= vrd;
								bc_q <= rcol_s1;
								ov_q <= bv_q;
							end else if (vrd > ov_q) ov_q <= vrd;
						end
						if ({1'b0, col_q} > {1'b0, fc[SW:0]} || col_q == (SW+1)'(MS)+1'b1)
							st_q <= ST_EMIT;
						else col_q <= col_q + 1'b1;
					end
				end
				ST_EMIT: if (emit_go) begin
					ref_star <= row_q;
					best_frame_star <= bc_q;
					corrected_vote <= bv_q - ov_q;
					overflow <= ovf_q;
					last <= {2'b0, row_q} + 1'b1 == rc;
					col_q <= '0;
					rd_s1 <= 1'b0;
					if ({2'b0, row_q} + 1'b1 == rc) begin
						st_q <= ST_IDLE;
						fcnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						row_q <= row_q + 1'b1;
						st_q <= ST_SCAN;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> in_stall) else $error("input taken during compute");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ref_star)))
		else $error("stalled result changed");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q <= CW'(tvsm_pkg::MaxTris))) else $error("ref count overran");
`endif
endmodule
`default_nettype wire
